### design/lpht_pkg.sv
package lpht_pkg;

    localparam int KIND_W   = 2;
    localparam int KLEN_W   = 4;
    localparam int KEY_W    = 64;
    localparam int EVAL_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FVAL_W   = 32;
    localparam int SIDX_W   = 10;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd4;

    localparam logic [63:0] HASH_START = 64'd5381;
    localparam int unsigned HASH_SHIFT = 5;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } slot_cmd_t;

endpackage

### design/lpht_slot_store.sv
module lpht_slot_store #(
    parameter int SLOTS = 1024,
    parameter int KW    = 64,
    parameter int LEN_W = 4,
    parameter int VW    = 32
) (
    input  logic                    clk,
    input  lpht_pkg::slot_cmd_t     cmd,
    input  logic [$clog2(SLOTS)-1:0] addr,
    input  logic [KW-1:0]           wr_key,
    input  logic [LEN_W-1:0]        wr_len,
    input  logic [VW-1:0]           wr_value,
    output logic                    occupied,
    output logic [KW-1:0]           rd_key,
    output logic [LEN_W-1:0]        rd_len,
    output logic [VW-1:0]           rd_value
);
    import lpht_pkg::*;

    logic             occ_mem [SLOTS];
    logic [KW-1:0]    key_mem [SLOTS];
    logic [LEN_W-1:0] len_mem [SLOTS];
    logic [VW-1:0]    val_mem [SLOTS];

    logic             occ_rd_reg;
    logic [KW-1:0]    key_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic [VW-1:0]    val_rd_reg;

    // The occupancy bits live apart so that a clear touches only them.
    always_ff @(posedge clk)
    begin
        if (cmd.wr || cmd.clr)
        begin
            occ_mem[addr] <= cmd.wr;
        end
        if (cmd.rd)
        begin
            occ_rd_reg <= occ_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            key_mem[addr] <= wr_key;
            len_mem[addr] <= wr_len;
            val_mem[addr] <= wr_value;
        end
        if (cmd.rd)
        begin
            key_rd_reg <= key_mem[addr];
            len_rd_reg <= len_mem[addr];
            val_rd_reg <= val_mem[addr];
        end
    end

    assign occupied = occ_rd_reg;
    assign rd_key   = key_rd_reg;
    assign rd_len   = len_rd_reg;
    assign rd_value = val_rd_reg;

endmodule

### design/linear_probe_hash_table_unit.sv
// Insert and search hash the key, then probe slots until a result word is loaded,
// with the hash step taking one key byte per cycle over the effective key length,
// and each probed slot passing through a read step and then a compare step.
// Clear resets one occupancy bit per cycle, then loads a result word; one item is in work at a time.
// After reset the block runs the same clearing pass with item_stall high.
// Reset is asynchronous and active low; the slot memories themselves are not reset.
module linear_probe_hash_table_unit #(
    parameter int SLOTS      = 1024,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [lpht_pkg::KIND_W-1:0]    kind,
    input  logic [lpht_pkg::KLEN_W-1:0]    key_length,
    input  logic [lpht_pkg::KEY_W-1:0]     key_bytes,
    input  logic [lpht_pkg::EVAL_W-1:0]    entry_value,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [lpht_pkg::STATUS_W-1:0]  status,
    output logic [lpht_pkg::FVAL_W-1:0]    found_value,
    output logic [lpht_pkg::SIDX_W-1:0]    slot_index
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int KW    = 8 * KEY_BYTES;
    localparam int LEN_W = $clog2(KEY_BYTES + 1);
    localparam int VW    = (VALUE_BITS < EVAL_W) ? VALUE_BITS : EVAL_W;
    localparam int EXT_W = (IDX_W > SIDX_W) ? IDX_W : SIDX_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = {IDX_W{1'b1}};

    logic [2:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [KW-1:0]       shift_reg, shift_next;
    logic [LEN_W-1:0]    hcnt_reg, hcnt_next;
    logic [IDX_W-1:0]    hash_reg, hash_next;
    logic [IDX_W-1:0]    probe_idx_reg, probe_idx_next;
    logic [IDX_W-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [VW-1:0]       value_reg, value_next;
    logic [IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic                clr_report_reg, clr_report_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VW-1:0]       res_value_reg, res_value_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FVAL_W-1:0]   fval_reg, fval_next;
    logic [SIDX_W-1:0]   sidx_reg, sidx_next;

    logic                item_acc;
    logic [LEN_W-1:0]    len_eff;
    logic [KW-1:0]       key_masked;
    logic [IDX_W-1:0]    hash_step;
    logic [EXT_W-1:0]    slot_ext;
    logic                out_free;

    slot_cmd_t           cmd;
    logic [IDX_W-1:0]    mem_addr;
    logic                occ_rd;
    logic [KW-1:0]       key_rd;
    logic [LEN_W-1:0]    len_rd;
    logic [VW-1:0]       val_rd;

    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (key_length > KLEN_W'(KEY_BYTES))
        begin
            len_eff = LEN_W'(KEY_BYTES);
        end
        else
        begin
            len_eff = LEN_W'(key_length);
        end
    end

    // Bytes at and above the effective length take no part in hash, store or compare.
    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            key_masked[8*b +: 8] = (LEN_W'(b) < len_eff) ? key_bytes[8*b +: 8] : 8'd0;
        end
    end

    // Only the low index bits of the hash survive the modulo, so the step runs narrow.
    assign hash_step = IDX_W'(hash_reg << HASH_SHIFT) + hash_reg + IDX_W'(shift_reg[7:0]);

    assign slot_ext = EXT_W'(res_slot_reg);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        len_next        = len_reg;
        key_next        = key_reg;
        shift_next      = shift_reg;
        hcnt_next       = hcnt_reg;
        hash_next       = hash_reg;
        probe_idx_next  = probe_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        value_next      = value_reg;
        clr_idx_next    = clr_idx_reg;
        clr_report_next = clr_report_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        fval_next       = fval_reg;
        sidx_next       = sidx_reg;
        cmd             = '0;
        mem_addr        = probe_idx_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    kind_next      = kind;
                    len_next       = len_eff;
                    key_next       = key_masked;
                    shift_next     = key_masked;
                    hcnt_next      = len_eff;
                    hash_next      = IDX_W'(HASH_START);
                    value_next     = VW'(entry_value);
                    res_value_next = '0;
                    res_slot_next  = '0;
                    case (kind) inside
                        KIND_INSERT, KIND_SEARCH:
                        begin
                            state_next = S_HASH;
                        end
                        KIND_CLEAR:
                        begin
                            res_status_next = STAT_CLEARED;
                            clr_idx_next    = '0;
                            clr_report_next = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        default:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                if (hcnt_reg == '0)
                begin
                    probe_idx_next = hash_reg;
                    probe_cnt_next = '0;
                    state_next     = S_READ;
                end
                else
                begin
                    hash_next  = hash_step;
                    shift_next = shift_reg >> 8;
                    hcnt_next  = hcnt_reg - LEN_W'(1);
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (kind_reg == KIND_INSERT && !occ_rd)
                begin
                    cmd.wr          = 1'b1;
                    res_status_next = STAT_INSERTED;
                    res_slot_next   = probe_idx_reg;
                    state_next      = S_FINISH;
                end
                else if (kind_reg == KIND_SEARCH && !occ_rd)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_FINISH;
                end
                else if (kind_reg == KIND_SEARCH && len_rd == len_reg && key_rd == key_reg)
                begin
                    res_status_next = STAT_FOUND;
                    res_value_next  = val_rd;
                    res_slot_next   = probe_idx_reg;
                    state_next      = S_FINISH;
                end
                else if (probe_cnt_reg == LAST_IDX)
                begin
                    // A full lap without a free slot or a match.
                    res_status_next = (kind_reg == KIND_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
                    state_next      = S_FINISH;
                end
                else
                begin
                    probe_idx_next = probe_idx_reg + IDX_W'(1);
                    probe_cnt_next = probe_cnt_reg + IDX_W'(1);
                    state_next     = S_READ;
                end
            end
            S_CLEAR:
            begin
                cmd.clr      = 1'b1;
                mem_addr     = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = clr_report_reg ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    fval_next      = FVAL_W'(res_value_reg);
                    sidx_next      = slot_ext[SIDX_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            clr_report_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_report_reg <= clr_report_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        len_reg        <= len_next;
        key_reg        <= key_next;
        shift_reg      <= shift_next;
        hcnt_reg       <= hcnt_next;
        hash_reg       <= hash_next;
        probe_idx_reg  <= probe_idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        fval_reg       <= fval_next;
        sidx_reg       <= sidx_next;
    end

    lpht_slot_store #(
        .SLOTS (SLOTS),
        .KW    (KW),
        .LEN_W (LEN_W),
        .VW    (VW)
    ) u_store (
        .clk      (clk),
        .cmd      (cmd),
        .addr     (mem_addr),
        .wr_key   (key_reg),
        .wr_len   (len_reg),
        .wr_value (value_reg),
        .occupied (occ_rd),
        .rd_key   (key_rd),
        .rd_len   (len_rd),
        .rd_value (val_rd)
    );

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign found_value  = fval_reg;
    assign slot_index   = sidx_reg;

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_READ))
        else $error("compare cycle without a preceding slot read");

    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> !occ_rd)
        else $error("insert wrote an occupied slot");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_FINISH))
        else $error("result word loaded outside the finish step");

    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_idx_reg == LAST_IDX)
        |=> (state_reg == S_IDLE || state_reg == S_FINISH))
        else $error("clearing pass did not end after the last slot");

endmodule
